// ===== hdl/ssfb_pkg.sv =====
// Shared types, command bytes and digit helpers for the seven-segment frame builder.
// No dependencies; every other file except ssfb_checker.sv imports this package.

package ssfb_pkg;

	typedef logic [3:0] code_t;

	// Request modes.
	localparam logic [1:0] ACT_INT    = 2'd0;
	localparam logic [1:0] ACT_CLOCK  = 2'd1;
	localparam logic [1:0] ACT_RAW    = 2'd2;
	localparam logic [1:0] ACT_SINGLE = 2'd3;

	// Command bytes for the driver chip.
	localparam logic [7:0] CMD_AUTO_INC  = 8'h40;
	localparam logic [7:0] CMD_FIXED     = 8'h44;
	localparam logic [7:0] CMD_ADDR_BASE = 8'hC0;
	localparam logic [7:0] CMD_CTRL      = 8'h80;

	// Special digit codes.
	localparam code_t CODE_BLANK = 4'd10;
	localparam code_t CODE_MINUS = 4'd11;

	// Integer and clock display limits.
	localparam logic signed [15:0] INT_MAX = 16'sd9999;
	localparam logic signed [15:0] INT_MIN = -16'sd999;
	localparam logic [7:0] HOURS_LIMIT   = 8'd100;
	localparam logic [7:0] MINUTES_LIMIT = 8'd60;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] number;
		logic [7:0]         hours;
		logic [7:0]         minutes;
		code_t              code_first;
		code_t              code_second;
		code_t              code_third;
		code_t              code_fourth;
		logic [1:0]         position;
		logic               display_on;
	} in_req_t;

	// Request as it moves through the digit pipeline. For integers, rem holds
	// the part of the magnitude not yet split into digits.
	typedef struct packed {
		logic [1:0]  action;
		logic        drop;
		logic        neg;
		logic [13:0] rem;
		code_t       thou;
		code_t       hund;
		code_t [3:0] codes;
		logic [1:0]  position;
		logic        display_on;
	} req_t;

	// Decimal digit of v in the place of unit, for v below ten units.
	// All nine thresholds are compared in parallel.
	function automatic code_t digit_of(input logic [13:0] v, input logic [13:0] unit);
		code_t d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if (v >= 14'(k * unit))
				d = 4'(k);
		end
		return d;
	endfunction

	function automatic logic [7:0] seg_of(input code_t c);
		logic [7:0] s;
		case (c)
			4'd0:       s = 8'h3F;
			4'd1:       s = 8'h06;
			4'd2:       s = 8'h5B;
			4'd3:       s = 8'h4F;
			4'd4:       s = 8'h66;
			4'd5:       s = 8'h6D;
			4'd6:       s = 8'h7D;
			4'd7:       s = 8'h07;
			4'd8:       s = 8'h7F;
			4'd9:       s = 8'h6F;
			CODE_MINUS: s = 8'h40;
			default:    s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/ssfb_decode.sv =====
// Input register and mode decode: range checks, integer magnitude, clock digits.
// Depends on ssfb_pkg.

module ssfb_decode
	import ssfb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  in_req_t in_item,
	output logic    out_valid,
	input  logic    out_ready,
	output req_t    out_req
);

	logic    s1_valid_q;
	in_req_t s1_q;
	logic    s2_valid_q;
	req_t    s2_q;
	logic    s2_ready;
	req_t    req_d;
	logic [15:0] abs_v;
	code_t   h_tens;
	code_t   m_tens;

	assign s2_ready = !s2_valid_q || out_ready;
	assign in_ready = !s1_valid_q || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				s1_valid_q <= in_valid;
			if (s2_ready)
				s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			s1_q <= in_item;
		if (s1_valid_q && s2_ready)
			s2_q <= req_d;
	end

	always_comb begin
		abs_v  = s1_q.number[15] ? 16'(-s1_q.number) : s1_q.number;
		h_tens = digit_of({6'd0, s1_q.hours}, 14'd10);
		m_tens = digit_of({6'd0, s1_q.minutes}, 14'd10);

		req_d            = '0;
		req_d.action     = s1_q.action;
		req_d.position   = s1_q.position;
		req_d.display_on = s1_q.display_on;
		req_d.codes[0]   = s1_q.code_first;
		req_d.codes[1]   = s1_q.code_second;
		req_d.codes[2]   = s1_q.code_third;
		req_d.codes[3]   = s1_q.code_fourth;

		case (s1_q.action)
			ACT_INT: begin
				req_d.drop = (s1_q.number > INT_MAX) || (s1_q.number < INT_MIN);
				req_d.neg  = s1_q.number[15];
				req_d.rem  = abs_v[13:0];
			end
			ACT_CLOCK: begin
				req_d.drop     = (s1_q.hours >= HOURS_LIMIT) || (s1_q.minutes >= MINUTES_LIMIT);
				req_d.codes[0] = (h_tens == 4'd0) ? CODE_BLANK : h_tens;
				req_d.codes[1] = 4'(s1_q.hours - 8'(h_tens * 8'd10));
				req_d.codes[2] = m_tens;
				req_d.codes[3] = 4'(s1_q.minutes - 8'(m_tens * 8'd10));
			end
			default: begin
				req_d.drop = 1'b0;
			end
		endcase
	end

	assign out_valid = s2_valid_q;
	assign out_req   = s2_q;

endmodule

// ===== hdl/ssfb_digits.sv =====
// Two pipeline stages that split the thousands and hundreds digits off the
// integer magnitude. Depends on ssfb_pkg.

module ssfb_digits
	import ssfb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_req
);

	logic s3_valid_q;
	req_t s3_q;
	logic s4_valid_q;
	req_t s4_q;
	logic s4_ready;
	req_t s3_d;
	req_t s4_d;

	assign s4_ready = !s4_valid_q || out_ready;
	assign in_ready = !s3_valid_q || s4_ready;

	always_comb begin
		s3_d      = in_req;
		s3_d.thou = digit_of(in_req.rem, 14'd1000);
		s3_d.rem  = in_req.rem - 14'(s3_d.thou * 14'd1000);
	end

	always_comb begin
		s4_d      = s3_q;
		s4_d.hund = digit_of(s3_q.rem, 14'd100);
		s4_d.rem  = s3_q.rem - 14'(s4_d.hund * 14'd100);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
			s4_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				s3_valid_q <= in_valid;
			if (s4_ready)
				s4_valid_q <= s3_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			s3_q <= s3_d;
		if (s3_valid_q && s4_ready)
			s4_q <= s4_d;
	end

	assign out_valid = s4_valid_q;
	assign out_req   = s4_q;

endmodule

// ===== hdl/ssfb_serializer.sv =====
// Final digit split, zero blanking, segment mapping, frame register and the
// byte sequencer with its output register. Depends on ssfb_pkg.

module ssfb_serializer
	import ssfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  req_t       in_req,
	input  logic [2:0] brightness,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] bus_byte,
	output logic       opens_frame,
	output logic       closes_frame,
	output logic       last
);

	typedef struct packed {
		logic             single;
		logic [3:0][7:0]  seg;
		logic [1:0]       position;
		logic             display_on;
	} frame_t;

	frame_t     frame_d;
	frame_t     frame_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       opens_q;
	logic       closes_q;
	logic       last_q;

	code_t       tens;
	code_t       units;
	code_t [3:0] num_codes;
	code_t [3:0] sel_codes;
	logic  [3:0] lead;
	logic  [7:0] ctrl;
	logic  [7:0] byte_d;
	logic        opens_d;
	logic        closes_d;
	logic        last_d;
	logic        load;
	logic        take;

	// Integer digits with leading zeros blanked and the minus just before
	// the first shown digit.
	always_comb begin
		tens         = digit_of(in_req.rem, 14'd10);
		units        = 4'(in_req.rem - 14'(tens * 14'd10));
		num_codes[0] = in_req.thou;
		num_codes[1] = in_req.hund;
		num_codes[2] = tens;
		num_codes[3] = units;
		lead[0]      = (in_req.thou == 4'd0);
		lead[1]      = lead[0] && (in_req.hund == 4'd0);
		lead[2]      = lead[1] && (tens == 4'd0);
		lead[3]      = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (lead[i])
				num_codes[i] = (in_req.neg && !lead[i + 1]) ? CODE_MINUS : CODE_BLANK;
		end
		sel_codes = (in_req.action == ACT_INT) ? num_codes : in_req.codes;

		frame_d.single     = (in_req.action == ACT_SINGLE);
		frame_d.position   = in_req.position;
		frame_d.display_on = in_req.display_on;
		for (int i = 0; i < 4; i++)
			frame_d.seg[i] = seg_of(sel_codes[i]);
	end

	assign ctrl = CMD_CTRL | {4'd0, frame_q.display_on, brightness};

	always_comb begin
		byte_d   = '0;
		opens_d  = 1'b0;
		closes_d = 1'b0;
		last_d   = 1'b0;
		if (!frame_q.single) begin
			case (idx_q)
				3'd0: begin
					byte_d   = CMD_AUTO_INC;
					opens_d  = 1'b1;
					closes_d = 1'b1;
				end
				3'd1: begin
					byte_d  = CMD_ADDR_BASE;
					opens_d = 1'b1;
				end
				3'd2: byte_d = frame_q.seg[0];
				3'd3: byte_d = frame_q.seg[1];
				3'd4: byte_d = frame_q.seg[2];
				3'd5: begin
					byte_d   = frame_q.seg[3];
					closes_d = 1'b1;
				end
				3'd6: begin
					byte_d   = ctrl;
					opens_d  = 1'b1;
					closes_d = 1'b1;
					last_d   = 1'b1;
				end
				default: byte_d = '0;
			endcase
		end else begin
			case (idx_q)
				3'd0: begin
					byte_d   = CMD_FIXED;
					opens_d  = 1'b1;
					closes_d = 1'b1;
				end
				3'd1: begin
					byte_d  = CMD_ADDR_BASE | {6'd0, frame_q.position};
					opens_d = 1'b1;
				end
				3'd2: begin
					byte_d   = frame_q.seg[0];
					closes_d = 1'b1;
				end
				3'd3: begin
					byte_d   = ctrl;
					opens_d  = 1'b1;
					closes_d = 1'b1;
					last_d   = 1'b1;
				end
				default: byte_d = '0;
			endcase
		end
	end

	assign load     = busy_q && (!out_valid_q || out_ready);
	assign in_ready = !busy_q || (load && last_d);
	assign take     = in_valid && in_ready && !in_req.drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				if (last_d)
					busy_q <= 1'b0;
				idx_q <= idx_q + 3'd1;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			frame_q <= frame_d;
		if (load) begin
			byte_q   <= byte_d;
			opens_q  <= opens_d;
			closes_q <= closes_d;
			last_q   <= last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign bus_byte     = byte_q;
	assign opens_frame  = opens_q;
	assign closes_frame = closes_q;
	assign last         = last_q;

endmodule

// ===== hdl/seven_segment_frame_builder_core.sv =====
// Top level of the seven-segment frame builder.
// Depends on ssfb_pkg, ssfb_decode, ssfb_digits and ssfb_serializer.

// Each accepted request becomes the byte stream for a four-digit seven-segment
// driver chip: integer, clock and raw requests give seven output words (data
// command, address, four segment bytes, display control), a single-position
// request gives four, and an integer outside -999 to 9999 or a time with hours
// of 100 or more or minutes of 60 or more gives none. Requests enter a
// five-register pipeline (input register, decode, thousands digit, hundreds
// digit, frame register) and a new request is taken every cycle unless the
// busy sequencer has backed the pipeline up. The sequencer sends one word per
// cycle through its output register while the output is ready, so a displayed
// request holds the output for its seven words, or four in single-position
// mode, and the next frame follows with no gap; a rejected request passes
// through each stage and adds nothing at the output. Brightness is written
// through the cfg channel, which is always ready, and resets to 7; write it
// only while no request is in flight.

module seven_segment_frame_builder_core
	import ssfb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [15:0] number,
	input  logic [7:0]         hours,
	input  logic [7:0]         minutes,
	input  logic [3:0]         code_first,
	input  logic [3:0]         code_second,
	input  logic [3:0]         code_third,
	input  logic [3:0]         code_fourth,
	input  logic [1:0]         position,
	input  logic               display_on,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         bus_byte,
	output logic               opens_frame,
	output logic               closes_frame,
	output logic               last
);

	// The brightness register lives here, since only the control byte uses it.
	logic [2:0] brightness_q;

	in_req_t in_item;
	logic    dec_valid;
	logic    dec_ready;
	req_t    dec_req;
	logic    dig_valid;
	logic    dig_ready;
	req_t    dig_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			brightness_q <= 3'd7;
		else if (cfg_valid && cfg_ready)
			brightness_q <= cfg_data;
	end

	// Gather the request fields into one word for the pipeline.
	always_comb begin
		in_item.action      = action;
		in_item.number      = number;
		in_item.hours       = hours;
		in_item.minutes     = minutes;
		in_item.code_first  = code_first;
		in_item.code_second = code_second;
		in_item.code_third  = code_third;
		in_item.code_fourth = code_fourth;
		in_item.position    = position;
		in_item.display_on  = display_on;
	end

	// Input register and decode: range checks, magnitude, clock digits.
	ssfb_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_req   (dec_req)
	);

	// Thousands and hundreds digits, one per stage.
	ssfb_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_req    (dec_req),
		.out_valid (dig_valid),
		.out_ready (dig_ready),
		.out_req   (dig_req)
	);

	// Tens and units, blanking, segment lookup and the byte sequencer.
	// Rejected requests are consumed here without producing a word.
	ssfb_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (dig_valid),
		.in_ready     (dig_ready),
		.in_req       (dig_req),
		.brightness   (brightness_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bus_byte     (bus_byte),
		.opens_frame  (opens_frame),
		.closes_frame (closes_frame),
		.last         (last)
	);

endmodule

// ===== hdl/ssfb_checker.sv =====
// Port-level checks for the seven-segment frame builder and the bind that
// attaches them to seven_segment_frame_builder_core. Depends on no package.

module ssfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] bus_byte,
	input logic       opens_frame,
	input logic       closes_frame,
	input logic       last
);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bus_byte) && $stable(last))
		else $error("output word changed while stalled");

	// The final word of a request is the control byte in a frame of its own.
	a_last_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> opens_frame && closes_frame && (bus_byte[7:4] == 4'h8))
		else $error("last word is not a framed control byte");

	// A frame opened without being closed starts with an address command.
	a_addr_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && opens_frame && !closes_frame |-> (bus_byte[7:2] == 6'b110000))
		else $error("open frame does not start with an address command");

	// After the last word of a request is taken, the next word opens a data command frame.
	a_next_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last ##1 out_valid |->
			opens_frame && closes_frame && !last &&
			((bus_byte == 8'h40) || (bus_byte == 8'h44)))
		else $error("request does not start with a data command");

endmodule

bind seven_segment_frame_builder_core ssfb_checker u_ssfb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.bus_byte     (bus_byte),
	.opens_frame  (opens_frame),
	.closes_frame (closes_frame),
	.last         (last)
);
